FILE: src/fixed_point_q24_8_alu_top_assert.svh
// Assertion macros for the fixed-point ALU checker.
// Included by the checker file only; no other dependencies.
`ifndef FIXED_POINT_Q24_8_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_TOP_ASSERT_SVH

// clocked assertion, off while reset is low
`define FXA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs through reset
`define FXA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/fxa_pkg.sv
// Package for the fixed-point ALU: opcodes, request/result structs, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fxa_pkg;

    localparam int DEF_FRAC_BITS = 8;
    localparam int WORD_W = 32;

    typedef enum logic [3:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_MUL  = 4'd2,
        FN_DIV  = 4'd3,
        FN_GT   = 4'd4,
        FN_LT   = 4'd5,
        FN_GE   = 4'd6,
        FN_LE   = 4'd7,
        FN_EQ   = 4'd8,
        FN_NE   = 4'd9,
        FN_MIN  = 4'd10,
        FN_MAX  = 4'd11,
        FN_INC  = 4'd12,
        FN_DEC  = 4'd13,
        FN_FROM = 4'd14,
        FN_TO   = 4'd15
    } t_func;

    typedef struct packed {
        t_func              func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               div_zero;
        logic               overflow;
    } t_res;

    // per-request sideband that travels alongside the divider
    typedef struct packed {
        logic        valid;
        t_func       func;
        logic        neg;
        logic        dz;
        logic        cmp;
        logic        ov;
        logic [31:0] res;
    } t_side;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

    // {ov, value} from a 33-bit signed sum
    function automatic logic [32:0] sat33(input logic [32:0] s);
        if (s[32] != s[31]) begin
            return {1'b1, (s[32] ? NEG_MIN : POS_MAX)};
        end
        return {1'b0, s[31:0]};
    endfunction

    // {ov, value} from sign and magnitude
    function automatic logic [32:0] clamp_mag(input logic neg, input logic [63:0] mag);
        logic [63:0] t;
        t = 64'd0 - mag;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                return {1'b1, NEG_MIN};
            end
            return {1'b0, t[31:0]};
        end
        if (mag > 64'h0000_0000_7FFF_FFFF) begin
            return {1'b1, POS_MAX};
        end
        return {1'b0, mag[31:0]};
    endfunction

endpackage
`default_nettype wire

FILE: src/fixed_point_q24_8_alu_top.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fxa_pkg, fxa_front, fxa_div_pipe.
//
// Usage:
//   Request channel: drive i_req and raise start; the request is taken at a
//   rising edge where start is high and busy is low. busy is high only in
//   and just after reset, so one request can be taken every cycle.
//   Result channel: o_res is shown for exactly one cycle with o_done high;
//   the receiver must take it then and cannot stall the block.
// Pipeline from request to result (Q24.8 when FRAC_BITS is 8):
//   three front stages (input, simple ops and multiply, multiply rounding),
//   one divider stage per quotient bit (32 + FRAC_BITS), a divide rounding
//   stage and the output register. Every opcode takes the same path, so
//   results come back in request order.
// Throughput: one request per cycle while busy is low, set by the fully pipelined divider.
// Reset: synchronous, active low; all in-flight requests are dropped and
//   busy stays high until the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu_top #(
    parameter int FRAC_BITS = fxa_pkg::DEF_FRAC_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    input  wire fxa_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output fxa_pkg::t_res      o_res
);
    import fxa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;

    logic r_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    t_side         f_side, d_side;
    logic [NW-1:0] f_num, d_quo;
    logic [31:0]   f_den, d_rem, d_den;

    fxa_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !r_busy),
        .i_req   (i_req),
        .o_side  (f_side),
        .o_num   (f_num),
        .o_den   (f_den)
    );

    fxa_div_pipe #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (f_side),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_side  (d_side),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_den   (d_den)
    );

    // divide rounding: half away from zero on the magnitude
    t_side       r_rnd_side;
    logic [NW:0] r_rnd_q;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_side.valid <= 1'b0;
        end else begin
            r_rnd_side <= d_side;
        end
        r_rnd_q <= {1'b0, d_quo} + (NW+1)'({d_rem, 1'b0} >= {1'b0, d_den});
    end

    // output register
    t_res  n_res, r_res;
    logic  r_done;
    logic [32:0] div_sat;

    always_comb begin
        div_sat            = clamp_mag(r_rnd_side.neg, 64'(r_rnd_q));
        n_res.result_value = r_rnd_side.res;
        n_res.compare_true = r_rnd_side.cmp;
        n_res.div_zero     = r_rnd_side.dz;
        n_res.overflow     = r_rnd_side.ov;
        if (r_rnd_side.func == FN_DIV) begin
            if (r_rnd_side.dz) begin
                n_res.result_value = 32'sd0;
                n_res.overflow     = 1'b0;
            end else begin
                n_res.result_value = div_sat[31:0];
                n_res.overflow     = div_sat[32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_rnd_side.valid;
        end
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

FILE: src/fxa_front.sv
// Front stages: input register, simple ops and multiply, multiply rounding.
// Depends on fxa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fxa_front #(
    parameter int FRAC_BITS = fxa_pkg::DEF_FRAC_BITS,
    parameter int NW        = 32 + FRAC_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  wire fxa_pkg::t_req i_req,
    output fxa_pkg::t_side     o_side,
    output logic [NW-1:0]      o_num,
    output logic [31:0]        o_den
);
    import fxa_pkg::*;

    localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

    // stage 1
    logic        r1_v;
    t_req        r1_req;
    logic [31:0] r1_ma, r1_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
        end
        r1_req <= i_req;
        r1_ma  <= i_req.operand_a[31] ? 32'd0 - i_req.operand_a : i_req.operand_a;
        r1_mb  <= i_req.operand_b[31] ? 32'd0 - i_req.operand_b : i_req.operand_b;
    end

    // stage 2
    t_side       n2_side, r2_side;
    logic [63:0] r2_prod;
    logic [NW-1:0] r2_num;
    logic [31:0] r2_den;

    logic signed [31:0] a, b;
    logic [32:0] s_add, s_sub, s_inc, s_dec;
    logic signed [63:0] w_from;

    always_comb begin
        a = $signed(r1_req.operand_a);
        b = $signed(r1_req.operand_b);
        s_add  = sat33({a[31], a} + {b[31], b});
        s_sub  = sat33({a[31], a} - {b[31], b});
        s_inc  = sat33({a[31], a} + 33'd1);
        s_dec  = sat33({a[31], a} - 33'd1);
        w_from = 64'(a) <<< FRAC_BITS;
        n2_side       = '0;
        n2_side.valid = r1_v;
        n2_side.func  = r1_req.func;
        n2_side.neg   = a[31] ^ b[31];
        n2_side.dz    = (r1_req.func == FN_DIV) && (b == 32'sd0);
        case (r1_req.func)
            FN_ADD: {n2_side.ov, n2_side.res} = s_add;
            FN_SUB: {n2_side.ov, n2_side.res} = s_sub;
            FN_INC: {n2_side.ov, n2_side.res} = s_inc;
            FN_DEC: {n2_side.ov, n2_side.res} = s_dec;
            FN_GT:  n2_side.cmp = a > b;
            FN_LT:  n2_side.cmp = a < b;
            FN_GE:  n2_side.cmp = a >= b;
            FN_LE:  n2_side.cmp = a <= b;
            FN_EQ:  n2_side.cmp = a == b;
            FN_NE:  n2_side.cmp = a != b;
            FN_MIN: n2_side.res = (a < b) ? a : b;
            FN_MAX: n2_side.res = (a > b) ? a : b;
            FN_FROM: begin
                if (w_from[63:31] != {33{w_from[63]}}) begin
                    n2_side.ov  = 1'b1;
                    n2_side.res = a[31] ? NEG_MIN : POS_MAX;
                end else begin
                    n2_side.res = w_from[31:0];
                end
            end
            FN_TO:  n2_side.res = a >>> FRAC_BITS;
            default: n2_side.res = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_side.valid <= 1'b0;
        end else begin
            r2_side <= n2_side;
        end
        r2_prod <= 64'(r1_ma) * 64'(r1_mb);
        r2_num  <= NW'(r1_ma) << FRAC_BITS;
        r2_den  <= r1_mb;
    end

    // stage 3: multiply rounding and saturation
    t_side       n3_side, r3_side;
    logic [63:0] m_rnd;

    always_comb begin
        m_rnd   = (r2_prod + HALF) >> FRAC_BITS;
        n3_side = r2_side;
        if (r2_side.func == FN_MUL) begin
            {n3_side.ov, n3_side.res} = clamp_mag(r2_side.neg, m_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side.valid <= 1'b0;
        end else begin
            r3_side <= n3_side;
        end
        o_num <= r2_num;
        o_den <= r2_den;
    end

    assign o_side = r3_side;

endmodule
`default_nettype wire

FILE: src/fxa_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage; carries sideband.
// Depends on fxa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fxa_div_pipe #(
    parameter int NW = 32 + fxa_pkg::DEF_FRAC_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire fxa_pkg::t_side i_side,
    input  wire [NW-1:0]        i_num,
    input  wire [31:0]          i_den,
    output fxa_pkg::t_side      o_side,
    output logic [NW-1:0]       o_quo,
    output logic [31:0]         o_rem,
    output logic [31:0]         o_den
);
    import fxa_pkg::*;

    t_side         r_side [NW];
    logic [31:0]   r_rem  [NW];
    logic [NW-1:0] r_nq   [NW];
    logic [31:0]   r_den  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        t_side         s_in;
        logic [31:0]   rem_in, den_in;
        logic [NW-1:0] nq_in;
        logic [32:0]   t, d;
        logic          ge;

        if (k == 0) begin : g_first
            assign s_in   = i_side;
            assign rem_in = 32'd0;
            assign nq_in  = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign s_in   = r_side[k-1];
            assign rem_in = r_rem[k-1];
            assign nq_in  = r_nq[k-1];
            assign den_in = r_den[k-1];
        end

        assign t  = {rem_in, nq_in[NW-1]};
        assign ge = t >= {1'b0, den_in};
        assign d  = t - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else begin
                r_side[k] <= s_in;
            end
            r_rem[k] <= ge ? d[31:0] : t[31:0];
            r_nq[k]  <= {nq_in[NW-2:0], ge};
            r_den[k] <= den_in;
        end
    end

    assign o_side = r_side[NW-1];
    assign o_quo  = r_nq[NW-1];
    assign o_rem  = r_rem[NW-1];
    assign o_den  = r_den[NW-1];

endmodule
`default_nettype wire

FILE: src/fxa_chk.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fxa_pkg and fixed_point_q24_8_alu_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_q24_8_alu_top_assert.svh"
module fxa_chk #(
    parameter int FRAC_BITS = fxa_pkg::DEF_FRAC_BITS
) (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                start,
    input wire                busy,
    input wire                o_done,
    input wire fxa_pkg::t_res o_res
);
    import fxa_pkg::*;

    localparam int LAT = 37 + FRAC_BITS;

    `FXA_ASSERT(a_lat, i_clk, i_rst_n, o_done |-> $past(start && !busy, LAT), "result without request")
    `FXA_ASSERT(a_dz, i_clk, i_rst_n, (o_done && o_res.div_zero) |-> (o_res.result_value == 32'sd0 && !o_res.overflow && !o_res.compare_true), "div by zero result not clean")
    `FXA_ASSERT(a_cmp, i_clk, i_rst_n, (o_done && o_res.compare_true) |-> (o_res.result_value == 32'sd0 && !o_res.overflow), "compare result not zero")
    `FXA_ASSERT_NR(a_rst, i_clk, !i_rst_n |=> (!o_done && busy), "activity right after reset")

endmodule
`default_nettype wire

bind fixed_point_q24_8_alu_top fxa_chk #(.FRAC_BITS(FRAC_BITS)) u_fxa_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

FILE: tb/sv/fxa_checker.sv
// Checker for the Q24.8 fixed-point ALU: watches requests and results,
// predicts each result exactly and compares field by field. Depends on fxa_pkg.
`timescale 1ns / 1ps
module fxa_checker (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           start,
    input  wire           busy,
    input  fxa_pkg::t_req i_req,
    input  wire           o_done,
    input  fxa_pkg::t_res o_res,
    output int            err_count,
    output int            pending,
    output int            seen
);
    import fxa_pkg::*;

    localparam int FB = 8;
    localparam longint PMAX = 64'sd2147483647;
    localparam longint NMIN = -64'sd2147483648;

    t_res want_q[$];

    initial begin
        err_count = 0;
        seen = 0;
        pending = 0;
    end

    function automatic t_res sat_signed(input longint v);
        t_res r;
        r = '0;
        if (v > PMAX) begin
            r.result_value = PMAX[31:0];
            r.overflow = 1'b1;
        end else if (v < NMIN) begin
            r.result_value = NMIN[31:0];
            r.overflow = 1'b1;
        end else begin
            r.result_value = v[31:0];
        end
        return r;
    endfunction

    function automatic t_res sat_mag(input bit neg, input longint unsigned mag);
        t_res r;
        longint v;
        r = '0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin
                r.result_value = NMIN[31:0];
                r.overflow = 1'b1;
            end else begin
                v = -longint'(mag);
                r.result_value = v[31:0];
            end
        end else if (mag > 64'h7FFF_FFFF) begin
            r.result_value = PMAX[31:0];
            r.overflow = 1'b1;
        end else begin
            r.result_value = mag[31:0];
        end
        return r;
    endfunction

    function automatic t_res alu_predict(input t_req q);
        t_res r;
        longint a, b;
        longint unsigned ma, mb, m, num, quo, rem;
        r = '0;
        a = longint'(q.operand_a);
        b = longint'(q.operand_b);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        case (q.func)
            FN_ADD: r = sat_signed(a + b);
            FN_SUB: r = sat_signed(a - b);
            FN_MUL: begin
                m = (ma * mb + (64'd1 << (FB - 1))) >> FB;
                r = sat_mag((a < 0) != (b < 0), m);
            end
            FN_DIV: begin
                if (b == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    num = ma << FB;
                    quo = num / mb;
                    rem = num % mb;
                    if (2 * rem >= mb) quo++;
                    r = sat_mag((a < 0) != (b < 0), quo);
                end
            end
            FN_GT: r.compare_true = a > b;
            FN_LT: r.compare_true = a < b;
            FN_GE: r.compare_true = a >= b;
            FN_LE: r.compare_true = a <= b;
            FN_EQ: r.compare_true = a == b;
            FN_NE: r.compare_true = a != b;
            FN_MIN: r.result_value = (a < b) ? q.operand_a : q.operand_b;
            FN_MAX: r.result_value = (a > b) ? q.operand_a : q.operand_b;
            FN_INC: r = sat_signed(a + 1);
            FN_DEC: r = sat_signed(a - 1);
            FN_FROM: r = sat_signed(a * (64'sd1 <<< FB));
            default: r.result_value = q.operand_a >>> FB;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, exp, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && o_done) begin
            seen++;
            if (want_q.size() == 0) begin
                report_mismatch("unexpected result", o_res, 0);
            end else begin
                w = want_q.pop_front();
                if (o_res.result_value !== w.result_value)
                    report_mismatch("result_value", o_res.result_value, w.result_value);
                if (o_res.compare_true !== w.compare_true)
                    report_mismatch("compare_true", o_res.compare_true, w.compare_true);
                if (o_res.div_zero !== w.div_zero)
                    report_mismatch("div_zero", o_res.div_zero, w.div_zero);
                if (o_res.overflow !== w.overflow)
                    report_mismatch("overflow", o_res.overflow, w.overflow);
            end
        end
        if (i_rst_n && start && !busy) want_q.push_back(alu_predict(i_req));
        pending = want_q.size();
    end
endmodule

FILE: tb/sv/tb_fixed_point_q24_8_alu_top.sv
// Testbench top for the Q24.8 fixed-point ALU: directed edge cases, then
// random requests under several idle patterns. Depends on fxa_pkg, fxa_checker.
`timescale 1ns / 1ps
module tb_fixed_point_q24_8_alu_top;
    import fxa_pkg::*;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_req  i_req = '0;
    logic  busy;
    logic  o_done;
    t_res  o_res;
    int    err_count, pending, seen;
    int    cycles = 0;
    int    sent = 0;
    int    idle_pct = 0;

    localparam int LIMIT = 200000;

    fixed_point_q24_8_alu_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_req(i_req),
        .busy(busy), .o_done(o_done), .o_res(o_res)
    );

    fxa_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_done(o_done), .o_res(o_res), .err_count(err_count), .pending(pending),
        .seen(seen)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_fixed_point_q24_8_alu_top: done, errors");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            3: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
            4: return $urandom_range(0, 2047) - 1024;
            5: return $urandom_range(0, 1 << 20) - (1 << 19);
            6: return $urandom_range(0, 1) ? 32'h0000_0100 : 32'hFFFF_FF00;
            default: return $urandom;
        endcase
    endfunction

    // called right after a rising edge; holds one request until accepted
    task automatic send_req(input t_func f, input logic [31:0] a, input logic [31:0] b);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            i_req <= '{func: t_func'($urandom_range(0, 15)), operand_a: $urandom,
                       operand_b: $urandom};
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{func: f, operand_a: a, operand_b: b};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    initial begin
        t_func f;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_req(FN_ADD, 32'h7FFF_FFFF, 32'd1);
        send_req(FN_ADD, 32'h8000_0000, 32'h8000_0000);
        send_req(FN_SUB, 32'h8000_0000, 32'd1);
        send_req(FN_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_req(FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_req(FN_MUL, 32'h8000_0000, 32'h8000_0000);
        send_req(FN_MUL, 32'h0000_0180, 32'h0000_0001);
        send_req(FN_MUL, 32'hFFFF_FE80, 32'h0000_0001);
        send_req(FN_DIV, 32'h0000_1234, 32'd0);
        send_req(FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        send_req(FN_DIV, 32'h0000_0001, 32'h0000_0200);
        send_req(FN_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
        send_req(FN_DIV, 32'h8000_0000, 32'h8000_0000);
        for (int k = 4; k <= 9; k++) send_req(t_func'(k), 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(FN_EQ, 32'h1234_5678, 32'h1234_5678);
        send_req(FN_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(FN_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        send_req(FN_INC, 32'h7FFF_FFFF, 32'd0);
        send_req(FN_DEC, 32'h8000_0000, 32'd0);
        send_req(FN_FROM, 32'h0080_0000, 32'd0);
        send_req(FN_FROM, 32'hFF7F_FFFF, 32'd0);
        send_req(FN_TO, 32'hFFFF_FF01, 32'd0);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 60 : (ph == 2) ? 23 : 0;
            for (int n = 0; n < 425; n++) begin
                f = t_func'($urandom_range(0, 15));
                send_req(f, pick_word(), pick_word());
            end
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d requests, %0d results, all 16 functions, saturation edges",
                 sent, seen);
        if (err_count == 0 && pending == 0) begin
            $display("tb_fixed_point_q24_8_alu_top: done, clean");
        end else begin
            $display("tb_fixed_point_q24_8_alu_top: done, errors");
        end
        $finish;
    end
endmodule
